>>> rtl/core/clsr_pkg.sv
`timescale 1ns / 1ps

package clsr_pkg;

	localparam int DEF_COLUMNS = 16;
	localparam int DEF_ROWS    = 2;

	localparam logic [7:0] ADDR_LINE_A = 8'h80;
	localparam logic [7:0] ADDR_LINE_B = 8'hC0;
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] SPACE_CODE  = 8'h20;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_PRINT = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	// Cursor control: load from the item, step to the next cell, return home
	typedef struct packed {
		logic load;
		logic step;
		logic zero;
	} cursor_ctl_t;

	function automatic int width_of(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// Set-DDRAM-address command for a cell; rows 2 and 3 continue lines A and B
	function automatic logic [7:0] lcd_address(input logic [1:0] row, input logic [7:0] col,
			input int columns);
		logic [7:0] base;
		base = row[0] ? ADDR_LINE_B : ADDR_LINE_A;
		if (row[1]) begin
			base = base + 8'(columns);
		end
		return base + col;
	endfunction

endpackage

>>> rtl/core/clsr_ram.sv
`timescale 1ns / 1ps

module clsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/clsr_cursor.sv
`timescale 1ns / 1ps

module clsr_cursor import clsr_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS,
	parameter int COL_W   = width_of(COLUMNS),
	parameter int ROW_W   = width_of(ROWS)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cursor_ctl_t      ctl,
	input  logic [3:0]       load_col,
	input  logic [1:0]       load_row,
	output logic [COL_W-1:0] col,
	output logic [ROW_W-1:0] row
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_nxt;
	logic [ROW_W-1:0] row_nxt;

	// Effective position for this item: clamp a loaded start onto the display
	always_comb begin
		col = col_q;
		row = row_q;
		if (ctl.load) begin
			col = (int'(load_col) >= COLUMNS) ? COL_W'(COLUMNS - 1) : COL_W'(load_col);
			row = (int'(load_row) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(load_row);
		end
	end

	// Advance across the columns, wrap to the next row and back to row 0
	always_comb begin
		col_nxt = COL_W'(int'(col) + 1);
		row_nxt = row;
		if (int'(col) + 1 >= COLUMNS) begin
			col_nxt = '0;
			row_nxt = (int'(row) + 1 >= ROWS) ? '0 : ROW_W'(int'(row) + 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.zero) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.step) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

endmodule

>>> rtl/core/char_lcd_shadow_refresh_unit.sv
`timescale 1ns / 1ps

// Shadow copy of a character LCD, refreshed one cell per tick.
// Command channel: an item (action, start_text, column, row, character) is
// taken at a rising edge with start high and busy low.
// Result channel: each LCD bus write (to_data_reg, bus_byte, last) shows for
// exactly one cycle with strobe high; the receiver cannot hold it off.
// Latency: the first result appears in the cycle after the item is taken.
// A refresh tick gives the set-address command, then the cell byte in the
// following cycle; busy is high during that first result cycle, so no new
// item is taken between the two. Print and clear items do not raise busy (a
// clear gives the display-clear command, a print gives nothing), so such
// items can come back to back. The cell byte is read through the registered
// read port of the cell memory.
// Reset: all cells read as spaces through per-cell valid bits, and both the
// scan and write positions return to row 0 column 0; no clearing pass.
// A clear item drops all valid bits at once.
module char_lcd_shadow_refresh_unit import clsr_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic       start_text,
	input  logic [3:0] column,
	input  logic [1:0] row,
	input  logic [7:0] character,
	output logic       strobe,
	output logic       to_data_reg,
	output logic [7:0] bus_byte,
	output logic       last
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int COL_W = width_of(COLUMNS);
	localparam int ROW_W = width_of(ROWS);
	localparam int IDX_W = width_of(CELLS);

	logic accept;
	logic is_tick;
	logic is_print;
	logic is_clear;

	cursor_ctl_t wr_ctl;
	cursor_ctl_t sc_ctl;
	logic [COL_W-1:0] wr_col;
	logic [ROW_W-1:0] wr_row;
	logic [COL_W-1:0] sc_col;
	logic [ROW_W-1:0] sc_row;
	logic [IDX_W-1:0] wr_idx;
	logic [IDX_W-1:0] sc_idx;
	logic [7:0]       rdata;

	logic [CELLS-1:0] valid_q;
	logic             valid_s1;
	logic             phase_q;
	logic             strobe_q;
	logic             to_data_q;
	logic [7:0]       bus_byte_q;
	logic             last_q;

	assign accept = start & ~busy;
	assign busy   = phase_q;

	always_comb begin
		is_tick  = 1'b0;
		is_print = 1'b0;
		is_clear = 1'b0;
		case (action_t'(action))
			ACT_TICK:  is_tick  = accept;
			ACT_PRINT: is_print = accept;
			ACT_CLEAR: is_clear = accept;
			default: ;
		endcase
	end

	always_comb begin
		wr_ctl.load = is_print & start_text;
		wr_ctl.step = is_print;
		wr_ctl.zero = 1'b0;
		sc_ctl.load = 1'b0;
		sc_ctl.step = is_tick;
		sc_ctl.zero = is_clear;
	end

	clsr_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_wr_cursor (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (wr_ctl),
		.load_col(column),
		.load_row(row),
		.col     (wr_col),
		.row     (wr_row)
	);

	clsr_cursor #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_sc_cursor (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (sc_ctl),
		.load_col(column),
		.load_row(row),
		.col     (sc_col),
		.row     (sc_row)
	);

	assign wr_idx = IDX_W'(int'(wr_row) * COLUMNS + int'(wr_col));
	assign sc_idx = IDX_W'(int'(sc_row) * COLUMNS + int'(sc_col));

	clsr_ram #(
		.WIDTH(8),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (is_print),
		.waddr(wr_idx),
		.wdata(character),
		.raddr(sc_idx),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (is_clear) begin
			valid_q <= '0;
		end else if (is_print) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// Sample the cell's valid bit alongside the memory read
	always_ff @(posedge clk) begin
		if (is_tick) begin
			valid_s1 <= valid_q[sc_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			phase_q  <= is_tick;
			strobe_q <= is_tick | is_clear | phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (is_tick) begin
			to_data_q  <= 1'b0;
			bus_byte_q <= lcd_address(2'(sc_row), 8'(sc_col), COLUMNS);
			last_q     <= 1'b0;
		end else if (is_clear) begin
			to_data_q  <= 1'b0;
			bus_byte_q <= CMD_CLEAR;
			last_q     <= 1'b1;
		end else if (phase_q) begin
			to_data_q  <= 1'b1;
			bus_byte_q <= valid_s1 ? rdata : SPACE_CODE;
			last_q     <= 1'b1;
		end
	end

	assign strobe      = strobe_q;
	assign to_data_reg = to_data_q;
	assign bus_byte    = bus_byte_q;
	assign last        = last_q;

endmodule

>>> rtl/core/clsr_checker.sv
`timescale 1ns / 1ps

module clsr_checker import clsr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] action,
	input logic       strobe,
	input logic       to_data_reg,
	input logic [7:0] bus_byte,
	input logic       last
);

	// A tick gives its address command in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == ACT_TICK |=> strobe && !to_data_reg && !last)
		else $error("tick item did not give an address command");

	// The cell byte follows the address command directly, as the final write
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && to_data_reg && last)
		else $error("cell byte did not follow the address command");

	// No new item while the second write of a tick is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("busy low between the two writes of a tick");

	// A clear gives exactly the display-clear command
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == ACT_CLEAR |=>
			strobe && !to_data_reg && last && bus_byte == CMD_CLEAR)
		else $error("clear item did not give the display-clear command");

	// Data writes only ever come right after a write
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && to_data_reg |-> $past(strobe))
		else $error("data write without a preceding write");

endmodule

bind char_lcd_shadow_refresh_unit clsr_checker u_clsr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.action     (action),
	.strobe     (strobe),
	.to_data_reg(to_data_reg),
	.bus_byte   (bus_byte),
	.last       (last)
);
